// ===== rtl/core/srr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants for the selective-repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int HDR_BYTES = 5;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_NONE  = 2'd2,
        KIND_EMPTY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ADV
    } state_t;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// ===== rtl/core/srr_payload_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_payload_ram
// Payload byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srr_payload_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/selective_repeat_receiver_unit.sv =====
`timescale 1ns / 1ps
// Selective-repeat receiver.
// Packet bytes: one per cycle while in_ready is high; the result (acknowledge) is valid in
// the cycle after the last byte. Drain reads: a data byte passes ST_READ for the registered
// payload memory read; nothing-ready and empty-message results are registered from the
// request. A waiting result holds off the next request. Window advance after a stored
// packet: one filled slot per cycle, until an empty slot, the read slot or SEQ_SPACE slots.
// Reset (rst_n, asynchronous, active low) clears all control state and slot valid bits;
// the payload memory and slot lengths are not cleared and are only read for valid slots.
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit
// Top level: header parse, checksum, slot bookkeeping, drain and window advance.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_unit #(
    parameter int SEQ_SPACE    = 32,
    parameter int WINDOW       = 16,
    parameter int PACKET_BYTES = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] packet_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] ack_seq,
    output logic [7:0] data_byte,
    output logic       last_of_message
);
    import srr_pkg::*;

    localparam int PAYLOAD_MAX = PACKET_BYTES - HDR_BYTES;
    localparam int WIN_EFF     = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE;
    localparam int SW          = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int OW          = $clog2(PAYLOAD_MAX + 1);
    localparam int PW          = $clog2(PACKET_BYTES);
    localparam int DEPTH       = SEQ_SPACE * PAYLOAD_MAX;
    localparam int AW          = $clog2(DEPTH);

    // Wrapping increment of a slot index.
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s == SW'(SEQ_SPACE - 1)) ? '0 : s + SW'(1);
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [SEQ_SPACE-1:0] slot_valid_reg, slot_valid_next;
    logic [6:0]           slot_length [SEQ_SPACE];
    logic [SW-1:0] window_start_reg, window_start_next;
    logic [SW-1:0] read_slot_reg, read_slot_next;
    logic [OW-1:0] read_offset_reg, read_offset_next;
    logic [PW-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]    cur_len_reg, cur_len_next;
    logic [7:0]    cur_seq_reg, cur_seq_next;
    logic [15:0]   hdr_sum_reg, hdr_sum_next;
    logic [15:0]   run_sum_reg, run_sum_next;
    logic [7:0]    low_hold_reg, low_hold_next;
    logic          store_ok_reg, store_ok_next;
    logic [SW-1:0] adv_cnt_reg, adv_cnt_next;
    logic          rd_last_reg, rd_last_next;

    logic       ov_reg, ov_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] ack_reg, ack_next;
    logic       last_reg, last_next;
    logic       data_sel_reg, data_sel_next;
    logic [7:0] data_hold_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;
    logic          len_we;
    logic [SW-1:0] len_waddr;

    logic          accept;
    logic [SW-1:0] seq_slot;
    logic [SW:0]   win_dist;
    logic          seq_in_win;
    logic [PW:0]   off_full;

    assign in_ready = (state_reg == ST_IDLE) && !(ov_reg && !out_ready);
    assign accept   = in_valid && in_ready;

    srr_payload_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (packet_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            slot_length[len_waddr] <= cur_len_reg[6:0];
        end
    end

    // Slot of a sequence number; only used when it is below SEQ_SPACE.
    assign seq_slot   = packet_byte[SW-1:0];
    // Distance from the window start, wrapped round the sequence space.
    assign win_dist   = (seq_slot >= window_start_reg)
                      ? {1'b0, seq_slot} - {1'b0, window_start_reg}
                      : {1'b0, seq_slot} + (SW+1)'(SEQ_SPACE) - {1'b0, window_start_reg};
    assign seq_in_win = (32'(packet_byte) < SEQ_SPACE) && (32'(win_dist) < WIN_EFF);
    assign off_full   = {1'b0, byte_pos_reg} - (PW+1)'(HDR_BYTES);

    always_comb
    begin
        state_next        = state_reg;
        slot_valid_next   = slot_valid_reg;
        window_start_next = window_start_reg;
        read_slot_next    = read_slot_reg;
        read_offset_next  = read_offset_reg;
        byte_pos_next     = byte_pos_reg;
        cur_len_next      = cur_len_reg;
        cur_seq_next      = cur_seq_reg;
        hdr_sum_next      = hdr_sum_reg;
        run_sum_next      = run_sum_reg;
        low_hold_next     = low_hold_reg;
        store_ok_next     = store_ok_reg;
        adv_cnt_next      = adv_cnt_reg;
        rd_last_next      = rd_last_reg;
        ov_next           = ov_reg && !out_ready;
        kind_next         = kind_reg;
        ack_next          = ack_reg;
        last_next         = last_reg;
        data_sel_next     = data_sel_reg;
        ram_we            = 1'b0;
        ram_waddr         = AW'(32'(cur_seq_reg[SW-1:0]) * PAYLOAD_MAX + 32'(off_full));
        ram_raddr         = AW'(32'(read_slot_reg) * PAYLOAD_MAX + 32'(read_offset_reg));
        len_we            = 1'b0;
        len_waddr         = cur_seq_reg[SW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_READ)
                begin
                    if (!slot_valid_reg[read_slot_reg])
                    begin
                        ov_next = 1'b1; kind_next = KIND_NONE; ack_next = '0;
                        last_next = 1'b0; data_sel_next = 1'b0;
                    end
                    else if (slot_length[read_slot_reg] == 7'd0)
                    begin
                        ov_next = 1'b1; kind_next = KIND_EMPTY; ack_next = '0;
                        last_next = 1'b1; data_sel_next = 1'b0;
                        slot_valid_next[read_slot_reg] = 1'b0;
                        read_slot_next   = slot_inc(read_slot_reg);
                        read_offset_next = '0;
                    end
                    else
                    begin
                        rd_last_next = (32'(read_offset_reg) + 1 >=
                                        32'(slot_length[read_slot_reg]));
                        state_next = ST_READ;
                    end
                end
                else if (accept)
                begin
                    if (byte_pos_reg == PW'(0))
                    begin
                        cur_len_next = packet_byte; run_sum_next = '0;
                        low_hold_next = '0; store_ok_next = 1'b0;
                    end
                    else if (byte_pos_reg == PW'(1))
                    begin
                        cur_seq_next  = packet_byte;
                        store_ok_next = seq_in_win && !slot_valid_reg[seq_slot];
                    end
                    else if (byte_pos_reg == PW'(3))
                    begin
                        hdr_sum_next = {8'd0, packet_byte};
                    end
                    else if (byte_pos_reg == PW'(4))
                    begin
                        hdr_sum_next = {packet_byte, hdr_sum_reg[7:0]};
                    end
                    else if (byte_pos_reg >= PW'(HDR_BYTES))
                    begin
                        if (32'(off_full) < 32'(cur_len_reg) &&
                            32'(off_full) < PAYLOAD_MAX)
                        begin
                            ram_we = store_ok_reg;
                            if (off_full[0])
                                run_sum_next = oc_add(run_sum_reg,
                                                      {packet_byte, low_hold_reg});
                            else
                                low_hold_next = packet_byte;
                        end
                    end

                    if (32'(byte_pos_reg) + 1 < PACKET_BYTES)
                    begin
                        byte_pos_next = byte_pos_reg + PW'(1);
                    end
                    else
                    begin
                        byte_pos_next = '0;
                        // The last byte may still carry payload, so check the updated sums.
                        if (32'(cur_len_reg) <= PAYLOAD_MAX &&
                            ~(cur_len_reg[0] ? oc_add(run_sum_next, {8'd0, low_hold_next})
                                             : run_sum_next) == hdr_sum_next)
                        begin
                            ov_next = 1'b1; kind_next = KIND_ACK; ack_next = cur_seq_next;
                            last_next = 1'b0; data_sel_next = 1'b0;
                            if (store_ok_next)
                            begin
                                slot_valid_next[cur_seq_next[SW-1:0]] = 1'b1;
                                len_we       = 1'b1;
                                len_waddr    = cur_seq_next[SW-1:0];
                                adv_cnt_next = '0;
                                state_next   = ST_ADV;
                            end
                        end
                        store_ok_next = 1'b0;
                    end
                end
            end
            ST_READ:
            begin
                // Memory data for the request arrives now.
                ov_next = 1'b1; kind_next = KIND_DATA; ack_next = '0;
                data_sel_next = 1'b1; last_next = rd_last_reg;
                if (rd_last_reg)
                begin
                    slot_valid_next[read_slot_reg] = 1'b0;
                    read_slot_next   = slot_inc(read_slot_reg);
                    read_offset_next = '0;
                end
                else
                begin
                    read_offset_next = read_offset_reg + OW'(1);
                end
                state_next = ST_IDLE;
            end
            ST_ADV:
            begin
                // One filled slot passed per cycle.
                if (slot_valid_reg[window_start_reg])
                begin
                    window_start_next = slot_inc(window_start_reg);
                    adv_cnt_next      = adv_cnt_reg + SW'(1);
                    if (slot_inc(window_start_reg) == read_slot_reg ||
                        32'(adv_cnt_reg) + 1 >= SEQ_SPACE)
                        state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_valid_reg   <= '0;
            window_start_reg <= '0;
            read_slot_reg    <= '0;
            read_offset_reg  <= '0;
            byte_pos_reg     <= '0;
            cur_len_reg      <= '0;
            cur_seq_reg      <= '0;
            hdr_sum_reg      <= '0;
            run_sum_reg      <= '0;
            low_hold_reg     <= '0;
            store_ok_reg     <= 1'b0;
            adv_cnt_reg      <= '0;
            rd_last_reg      <= 1'b0;
            ov_reg           <= 1'b0;
            kind_reg         <= '0;
            ack_reg          <= '0;
            last_reg         <= 1'b0;
            data_sel_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_valid_reg   <= slot_valid_next;
            window_start_reg <= window_start_next;
            read_slot_reg    <= read_slot_next;
            read_offset_reg  <= read_offset_next;
            byte_pos_reg     <= byte_pos_next;
            cur_len_reg      <= cur_len_next;
            cur_seq_reg      <= cur_seq_next;
            hdr_sum_reg      <= hdr_sum_next;
            run_sum_reg      <= run_sum_next;
            low_hold_reg     <= low_hold_next;
            store_ok_reg     <= store_ok_next;
            adv_cnt_reg      <= adv_cnt_next;
            rd_last_reg      <= rd_last_next;
            ov_reg           <= ov_next;
            kind_reg         <= kind_next;
            ack_reg          <= ack_next;
            last_reg         <= last_next;
            data_sel_reg     <= data_sel_next;
        end
    end

    // Capture read data so the result holds while stalled.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            data_hold_reg <= ram_rdata;
    end

    assign out_valid       = ov_reg;
    assign result_kind     = kind_reg;
    assign ack_seq         = ack_reg;
    assign data_byte       = data_sel_reg ? data_hold_reg : 8'd0;
    assign last_of_message = last_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (out_valid && result_kind == KIND_DATA))
        else $error("read produced no data result");
    a_adv_after_ack: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(state_reg == ST_ADV)) |-> (out_valid && result_kind == KIND_ACK))
        else $error("window advance without acknowledge");
endmodule
